[src/crl_pkg.sv]
`default_nettype none
package crl_pkg;
    localparam int TableEntries = 256;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = IdxW + 1;
    localparam logic [31:0] EmptyColor = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_STEP   = 2'd2,
        MODE_SMOOTH = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_DUP   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_PAIR_RD,
        S_PAIR_LAT,
        S_RESOLVE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_DIV_GO,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [32:0] num;
        logic [32:0] den;
    } t_div_req;
endpackage
`default_nettype wire

[src/color_ramp_lookup_top.sv]
`default_nettype none
// channel | dir | tdata (low bit up)               | tuser
// s_axis  | in  | key[31:0], entry_color[63:32]    | mode[1:0]
// m_axis  | out | color[31:0]                      | status[1:0]
// Lookup: each search probe runs S_DECIDE, S_SRCH_RD and S_SRCH_CMP, up to nine
// probes; then S_PAIR_RD, S_PAIR_LAT and S_RESOLVE fetch neighbours and resolve.
// Smooth blend: each of the four color bytes takes one run of the serial divider.
// Insert: search, a read and write per entry moved, one write; clear: no search.
// Reset: synchronous, empties the table; no clearing pass.
// Input is taken only in idle; a result held by m_axis_tready stalls the next one.
module color_ramp_lookup_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // key, entry_color
    input  wire logic [1:0]  s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // color
    output logic [1:0]       m_axis_tuser   // status
);
    localparam int IW = crl_pkg::IdxW;
    localparam int CW = crl_pkg::CntW;

    logic [63:0] r_mem [crl_pkg::TableEntries];
    logic [63:0] r_rd;
    logic [IW-1:0] n_ra;
    logic          n_we;
    logic [IW-1:0] n_wa;
    logic [63:0]   n_wd;

    crl_pkg::t_state r_st, n_st;
    crl_pkg::t_mode  r_mode;
    logic signed [31:0] r_key;
    logic [31:0] r_ecol;
    logic [CW-1:0] r_cnt, r_lo, r_hi, r_j;
    logic [31:0] r_c0, r_c1;
    logic signed [31:0] r_k0;
    logic [32:0] r_den;
    logic [31:0] r_col;
    crl_pkg::t_status r_stat;
    logic [31:0] r_ocol;
    crl_pkg::t_status r_ostat;
    logic        r_ovalid;
    logic [1:0]  r_bi;
    logic [23:0] r_acc;
    logic [CW-1:0] n_mid;
    logic signed [31:0] w_rkey;
    logic [31:0] w_rcol;
    logic        w_hit;
    logic        w_load;
    crl_pkg::t_div_req n_req;
    logic        w_ddone;
    logic [7:0]  w_dbyte;

    assign s_axis_tready = (r_st == crl_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ocol;
    assign m_axis_tuser  = r_ostat;
    assign n_mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign w_rkey = r_rd[31:0];
    assign w_rcol = r_rd[63:32];
    assign w_hit  = (r_lo < r_cnt) && (w_rkey == r_key);
    assign w_load = (r_st == crl_pkg::S_OUT) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_wa] <= n_wd;
        r_rd <= r_mem[n_ra];
    end

    crl_blend u_blend (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_req),
        .o_done (w_ddone),
        .o_byte (w_dbyte)
    );

    always_comb begin
        n_st = r_st;
        n_ra = n_mid[IW-1:0];
        n_we = 1'b0;
        n_wa = r_j[IW-1:0];
        n_wd = {r_ecol, r_key};
        n_req.start = 1'b0;
        n_req.a   = r_c0[8*r_bi +: 8];
        n_req.b   = r_c1[8*r_bi +: 8];
        n_req.num = {r_key[31], r_key} - {r_k0[31], r_k0};
        n_req.den = r_den;
        unique case (r_st)
            crl_pkg::S_IDLE: if (s_axis_tvalid) n_st = crl_pkg::S_DECIDE;
            crl_pkg::S_DECIDE: begin
                if (r_mode == crl_pkg::MODE_CLEAR) n_st = crl_pkg::S_OUT;
                else if (r_mode != crl_pkg::MODE_INSERT && r_cnt == '0) n_st = crl_pkg::S_OUT;
                else if (r_lo < r_hi) n_st = crl_pkg::S_SRCH_RD;
                else n_st = crl_pkg::S_PAIR_RD;
            end
            crl_pkg::S_SRCH_RD: n_st = crl_pkg::S_SRCH_CMP;
            crl_pkg::S_SRCH_CMP: n_st = crl_pkg::S_DECIDE;
            crl_pkg::S_PAIR_RD: begin
                n_ra = IW'(r_lo - 1'b1);
                n_st = crl_pkg::S_PAIR_LAT;
            end
            crl_pkg::S_PAIR_LAT: begin
                n_ra = r_lo[IW-1:0];
                n_st = crl_pkg::S_RESOLVE;
            end
            crl_pkg::S_RESOLVE: begin
                if (r_mode == crl_pkg::MODE_INSERT) begin
                    if (w_hit || r_cnt >= CW'(crl_pkg::TableEntries)) n_st = crl_pkg::S_OUT;
                    else if (r_cnt > r_lo) n_st = crl_pkg::S_SHIFT_RD;
                    else n_st = crl_pkg::S_INS_WR;
                end else if (r_lo >= r_cnt || w_hit || r_lo == '0
                             || r_mode == crl_pkg::MODE_STEP) begin
                    n_st = crl_pkg::S_OUT;
                end else begin
                    n_st = crl_pkg::S_DIV_GO;
                end
            end
            crl_pkg::S_SHIFT_RD: begin
                n_ra = IW'(r_j - 1'b1);
                n_st = crl_pkg::S_SHIFT_WR;
            end
            crl_pkg::S_SHIFT_WR: begin
                n_we = 1'b1;
                n_wd = r_rd;
                n_st = (r_j - 1'b1 > r_lo) ? crl_pkg::S_SHIFT_RD : crl_pkg::S_INS_WR;
            end
            crl_pkg::S_INS_WR: begin
                n_we = 1'b1;
                n_st = crl_pkg::S_OUT;
            end
            crl_pkg::S_DIV_GO: begin
                n_req.start = 1'b1;
                n_st = crl_pkg::S_DIV_WAIT;
            end
            crl_pkg::S_DIV_WAIT: begin
                if (w_ddone) n_st = (r_bi == 2'd3) ? crl_pkg::S_OUT : crl_pkg::S_DIV_GO;
            end
            crl_pkg::S_OUT: if (w_load) n_st = crl_pkg::S_IDLE;
            default: n_st = crl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= crl_pkg::S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_st)
                crl_pkg::S_IDLE: if (s_axis_tvalid) begin
                    r_mode <= crl_pkg::t_mode'(s_axis_tuser);
                    r_key  <= s_axis_tdata[31:0];
                    r_ecol <= s_axis_tdata[63:32];
                    r_lo   <= '0;
                    r_hi   <= r_cnt;
                end
                crl_pkg::S_DECIDE: begin
                    if (r_mode == crl_pkg::MODE_CLEAR) begin
                        r_cnt  <= '0;
                        r_col  <= '0;
                        r_stat <= crl_pkg::ST_OK;
                    end else if (r_mode != crl_pkg::MODE_INSERT && r_cnt == '0) begin
                        r_col  <= crl_pkg::EmptyColor;
                        r_stat <= crl_pkg::ST_EMPTY;
                    end
                end
                crl_pkg::S_SRCH_CMP: begin
                    if (w_rkey < r_key) r_lo <= n_mid + 1'b1;
                    else r_hi <= n_mid;
                end
                crl_pkg::S_PAIR_LAT: begin
                    r_c0 <= r_rd[63:32];
                    r_k0 <= r_rd[31:0];
                end
                crl_pkg::S_RESOLVE: begin
                    r_j   <= r_cnt;
                    r_c1  <= w_rcol;
                    r_den <= {w_rkey[31], w_rkey} - {r_k0[31], r_k0};
                    r_bi  <= 2'd0;
                    if (r_mode == crl_pkg::MODE_INSERT) begin
                        r_col <= '0;
                        if (w_hit) r_stat <= crl_pkg::ST_DUP;
                        else if (r_cnt >= CW'(crl_pkg::TableEntries)) r_stat <= crl_pkg::ST_FULL;
                        else r_stat <= crl_pkg::ST_OK;
                    end else begin
                        r_stat <= crl_pkg::ST_OK;
                        if (r_lo >= r_cnt) r_col <= r_c0;
                        else if (w_hit || r_lo == '0) r_col <= w_rcol;
                        else if (r_mode == crl_pkg::MODE_STEP) r_col <= r_c0;
                    end
                end
                crl_pkg::S_SHIFT_WR: r_j <= r_j - 1'b1;
                crl_pkg::S_INS_WR: r_cnt <= r_cnt + 1'b1;
                crl_pkg::S_DIV_WAIT: if (w_ddone) begin
                    r_acc <= {w_dbyte, r_acc[23:8]};
                    if (r_bi == 2'd3) r_col <= {w_dbyte, r_acc};
                    else r_bi <= r_bi + 2'd1;
                end
                crl_pkg::S_OUT: if (w_load) begin
                    r_ocol  <= r_col;
                    r_ostat <= r_stat;
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[src/crl_blend.sv]
`default_nettype none
module crl_blend (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire crl_pkg::t_div_req i_req,
    output logic                   o_done,
    output logic [7:0]             o_byte
);
    // restoring divide of diff*num by den, one quotient bit a cycle
    logic [40:0] r_dvd;
    logic [32:0] r_den;
    logic [40:0] r_quo;
    logic [33:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [7:0]  r_a;
    logic        r_up;
    logic [7:0]  r_diff;
    logic [1:0]  r_ph;
    logic [33:0] n_rem_sh;
    logic [33:0] n_rem_sub;
    logic [7:0]  n_q8;

    always_comb begin
        n_rem_sh  = {r_rem[32:0], r_dvd[40]};
        n_rem_sub = n_rem_sh - {1'b0, r_den};
        n_q8      = r_quo[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 2'd0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_ph   <= 2'd1;
                r_a    <= i_req.a;
                r_up   <= (i_req.b >= i_req.a);
                r_diff <= (i_req.b >= i_req.a) ? i_req.b - i_req.a : i_req.a - i_req.b;
                r_den  <= i_req.den;
                r_dvd  <= {8'd0, i_req.num};
            end else if (r_busy && r_ph == 2'd1) begin
                r_dvd <= 41'(r_dvd[32:0] * r_diff);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 6'd41;
                r_ph  <= 2'd2;
            end else if (r_busy && r_ph == 2'd2) begin
                r_dvd <= {r_dvd[39:0], 1'b0};
                if (!n_rem_sub[33]) begin
                    r_rem <= n_rem_sub;
                    r_quo <= {r_quo[39:0], 1'b1};
                end else begin
                    r_rem <= n_rem_sh;
                    r_quo <= {r_quo[39:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) r_ph <= 2'd3;
            end else if (r_busy && r_ph == 2'd3) begin
                r_busy <= 1'b0;
                r_ph   <= 2'd0;
                o_done <= 1'b1;
                o_byte <= r_up ? r_a + n_q8 : r_a - n_q8;
            end
        end
    end
endmodule
`default_nettype wire

[src/crl_checker.sv]
`default_nettype none
module crl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed under stall");
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");
    a_empty_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == crl_pkg::ST_EMPTY
        |-> m_axis_tdata == crl_pkg::EmptyColor)
        else $error("empty status without all-ones color");
    a_insert_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == crl_pkg::ST_FULL || m_axis_tuser == crl_pkg::ST_DUP)
        |-> m_axis_tdata == 32'd0)
        else $error("insert result with nonzero color");
endmodule

bind color_ramp_lookup_top crl_checker u_crl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
